@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every enabled clock edge
`define LGS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Expression must never be true on an enabled clock edge
`define LGS_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`endif

@@ hw/rtl/lgs_pkg.sv @@
// ----------------------------------------------------------------------------
// lgs_pkg
// Types, sizes and the B3/S23 rule shared by the life generation stencil.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // Board limits
    localparam int MAX_COLS  = 512;
    localparam int MAX_ROWS  = 1024;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    // input row counter also runs over the two drain rows
    localparam int IN_ROW_W  = ROW_W + 1;

    // Configuration port
    localparam int RCFG_W     = 11;
    localparam int CCFG_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(1);

    localparam logic [RCFG_W-1:0] RESET_ROWS = RCFG_W'(400);
    localparam logic [CCFG_W-1:0] RESET_COLS = CCFG_W'(400);

    // Input item
    typedef struct packed {
        logic mode;     // 1: drain tick
        logic cell_in;
    } t_lgs_in;

    // Result item
    typedef struct packed {
        logic             next_cell;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             last_of_frame;
    } t_lgs_out;

    // One line-buffer slot: row two above and row one above
    typedef struct packed {
        logic upper;
        logic middle;
    } t_lgs_pair;

    // Window control
    typedef struct packed {
        logic step;       // item transfer that moves the window
        logic first_col;  // item sits in column 0
        logic clear;      // frame restart
    } t_lgs_win_ctl;

    // B3/S23: born on 3, survives on 2 or 3
    function automatic logic next_state(input logic [8:0] win);
        logic [3:0] count;
        count = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                count = count + 4'(win[i]);
            end
        end
        return (count == 4'd3) || ((count == 4'd2) && win[4]);
    endfunction

endpackage

@@ hw/rtl/lgs_cell.sv @@
// ----------------------------------------------------------------------------
// lgs_cell
// One slot of the line buffer chain: holds a bit of each stored row.
// ----------------------------------------------------------------------------
module lgs_cell (
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic              i_tail,
    input  lgs_pkg::t_lgs_pair i_nbr,
    input  lgs_pkg::t_lgs_pair i_new,
    output lgs_pkg::t_lgs_pair o_q
);

    lgs_pkg::t_lgs_pair r_q;
    lgs_pkg::t_lgs_pair n_q;

    // tail slot takes the fresh column, others take the neighbor
    always_comb begin
        n_q = i_tail ? i_new : i_nbr;
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

@@ hw/rtl/lgs_line_chain.sv @@
// ----------------------------------------------------------------------------
// lgs_line_chain
// Line buffer built as a chain of cells; delay set by the active width.
// ----------------------------------------------------------------------------
module lgs_line_chain (
    input  logic                      i_clk,
    input  logic                      i_shift,
    input  logic [lgs_pkg::COL_W-1:0] i_tail_idx,
    input  lgs_pkg::t_lgs_pair        i_new,
    output lgs_pkg::t_lgs_pair        o_head
);

    lgs_pkg::t_lgs_pair w_q [lgs_pkg::MAX_COLS];

    // Data moves toward slot 0; entry point is slot cols-1
    for (genvar g = 0; g < lgs_pkg::MAX_COLS; g++) begin : g_cell
        lgs_pkg::t_lgs_pair w_nbr;
        logic               w_tail;

        if (g == lgs_pkg::MAX_COLS - 1) begin : g_end
            assign w_nbr = i_new;
        end else begin : g_mid
            assign w_nbr = w_q[g+1];
        end

        assign w_tail = (i_tail_idx == lgs_pkg::COL_W'(g));

        lgs_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_shift),
            .i_tail  (w_tail),
            .i_nbr   (w_nbr),
            .i_new   (i_new),
            .o_q     (w_q[g])
        );
    end

    assign o_head = w_q[0];

endmodule

@@ hw/rtl/lgs_window.sv @@
// ----------------------------------------------------------------------------
// lgs_window
// 3x3 neighborhood window and next-generation rule.
// ----------------------------------------------------------------------------
module lgs_window (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lgs_pkg::t_lgs_win_ctl i_ctl,
    input  logic [2:0]            i_col,   // bit0 top, bit1 middle, bit2 bottom
    output logic                  o_next
);

    logic [8:0] r_win;
    logic [8:0] n_win;

    // Column 0 evaluates the row-end window before reloading
    always_comb begin
        if (i_ctl.first_col) begin
            n_win  = {i_col, 6'b0};
            o_next = lgs_pkg::next_state({3'b0, r_win[8:3]});
        end else begin
            n_win  = {i_col, r_win[8:3]};
            o_next = lgs_pkg::next_state(n_win);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_win <= '0;
        end else if (i_ctl.step) begin
            r_win <= n_win;
        end
    end

endmodule

@@ hw/rtl/life_generation_stencil.sv @@
// ----------------------------------------------------------------------------
// life_generation_stencil
// One B3/S23 generation over a board streamed in row-major order.
// ----------------------------------------------------------------------------
// Takes one cell per clock and gives at most one result per cell transfer, so
// a frame of R x C cells runs at one item per cycle with no stalls of its own;
// only the downstream ready can hold it back. A result appears cols + 1 items
// after its cell: after the last cell, send cols + 1 drain items (mode 1) to
// flush the frame, and the final result carries last_of_frame. The two line
// stores are one shift chain of MAX_COLS cells, advancing on each cell or
// first-drain-row transfer, so the row delay follows cols_in_use without any
// addressed memory and no clearing pass is needed after reset. A write to
// either register restarts the frame; write only while the block is idle.
module life_generation_stencil (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  lgs_pkg::t_lgs_in               i_in_data,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output lgs_pkg::t_lgs_out              o_out_data,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lgs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Config registers
    logic [lgs_pkg::RCFG_W-1:0]   r_rows;
    logic [lgs_pkg::CCFG_W-1:0]   r_cols;
    // Stream positions
    logic [lgs_pkg::IN_ROW_W-1:0] r_in_row;
    logic [lgs_pkg::COL_W-1:0]    r_in_col;
    logic [lgs_pkg::ROW_W-1:0]    r_emit_row;
    logic [lgs_pkg::COL_W-1:0]    r_emit_col;
    // Output register
    logic                         r_out_valid;
    lgs_pkg::t_lgs_out            r_out_data;

    logic [lgs_pkg::RCFG_W-1:0]   w_eff_rows;
    logic [lgs_pkg::CCFG_W-1:0]   w_eff_cols;
    logic [lgs_pkg::ROW_W-1:0]    w_rows_m1;
    logic [lgs_pkg::COL_W-1:0]    w_cols_m1;
    logic                         w_in_fire;
    logic                         w_cfg_hit;
    logic                         w_live;
    logic                         w_act;
    logic                         w_first_col;
    logic                         w_emit;
    logic                         w_last;
    logic                         w_restart;
    logic                         w_bit;
    logic                         w_shift;
    logic [2:0]                   w_col;
    logic                         w_next;
    lgs_pkg::t_lgs_pair           w_head;
    lgs_pkg::t_lgs_pair           w_new;
    lgs_pkg::t_lgs_win_ctl        w_win_ctl;

    // Effective board size, clamped into range
    always_comb begin
        if (r_rows == '0) begin
            w_eff_rows = lgs_pkg::RCFG_W'(1);
        end else if (r_rows > lgs_pkg::RCFG_W'(lgs_pkg::MAX_ROWS)) begin
            w_eff_rows = lgs_pkg::RCFG_W'(lgs_pkg::MAX_ROWS);
        end else begin
            w_eff_rows = r_rows;
        end
        if (r_cols == '0) begin
            w_eff_cols = lgs_pkg::CCFG_W'(1);
        end else if (r_cols > lgs_pkg::CCFG_W'(lgs_pkg::MAX_COLS)) begin
            w_eff_cols = lgs_pkg::CCFG_W'(lgs_pkg::MAX_COLS);
        end else begin
            w_eff_cols = r_cols;
        end
    end

    assign w_rows_m1 = lgs_pkg::ROW_W'(w_eff_rows - lgs_pkg::RCFG_W'(1));
    assign w_cols_m1 = lgs_pkg::COL_W'(w_eff_cols - lgs_pkg::CCFG_W'(1));

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_cfg_hit   = i_cfg_valid &&
                         ((i_cfg_index == lgs_pkg::CFG_ROWS) ||
                          (i_cfg_index == lgs_pkg::CFG_COLS));

    // Item decode: drain ticks inside the board are dropped
    assign w_live      = ({1'b0, r_in_row} < {1'b0, w_eff_rows});
    assign w_act       = w_in_fire && !(w_live && i_in_data.mode) && !w_cfg_hit;
    assign w_first_col = (r_in_col == '0);
    assign w_bit       = w_live ? i_in_data.cell_in : 1'b0;
    assign w_shift     = w_act && ({1'b0, r_in_row} <= {1'b0, w_eff_rows});

    // Column entering the window; rows above the board read as dead
    assign w_col[0] = (r_in_row[lgs_pkg::IN_ROW_W-1:1] != '0) ? w_head.upper : 1'b0;
    assign w_col[1] = (r_in_row != '0) ? w_head.middle : 1'b0;
    assign w_col[2] = w_bit;

    assign w_new.upper  = w_head.middle;
    assign w_new.middle = w_bit;

    // Result timing
    assign w_emit    = w_act && (w_first_col ? (r_in_row[lgs_pkg::IN_ROW_W-1:1] != '0)
                                             : (r_in_row != '0));
    assign w_last    = (r_emit_row == w_rows_m1) && (r_emit_col == w_cols_m1);
    assign w_restart = w_cfg_hit || (w_emit && w_last);

    assign w_win_ctl.step      = w_act;
    assign w_win_ctl.first_col = w_first_col;
    assign w_win_ctl.clear     = w_restart;

    lgs_line_chain u_chain (
        .i_clk      (i_clk),
        .i_shift    (w_shift),
        .i_tail_idx (w_cols_m1),
        .i_new      (w_new),
        .o_head     (w_head)
    );

    lgs_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_win_ctl),
        .i_col   (w_col),
        .o_next  (w_next)
    );

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= lgs_pkg::RESET_ROWS;
            r_cols <= lgs_pkg::RESET_COLS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lgs_pkg::CFG_ROWS: r_rows <= i_cfg_data[lgs_pkg::RCFG_W-1:0];
                lgs_pkg::CFG_COLS: r_cols <= i_cfg_data[lgs_pkg::CCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Input stream position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_in_row <= '0;
            r_in_col <= '0;
        end else if (w_act) begin
            if (r_in_col == w_cols_m1) begin
                r_in_col <= '0;
                r_in_row <= r_in_row + lgs_pkg::IN_ROW_W'(1);
            end else begin
                r_in_col <= r_in_col + lgs_pkg::COL_W'(1);
            end
        end
    end

    // Result coordinates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_emit_row <= '0;
            r_emit_col <= '0;
        end else if (w_emit) begin
            if (r_emit_col == w_cols_m1) begin
                r_emit_col <= '0;
                r_emit_row <= r_emit_row + lgs_pkg::ROW_W'(1);
            end else begin
                r_emit_col <= r_emit_col + lgs_pkg::COL_W'(1);
            end
        end
    end

    // Output register; refills in the cycle its content transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data.next_cell     <= w_next;
            r_out_data.out_row       <= r_emit_row;
            r_out_data.out_col       <= r_emit_col;
            r_out_data.last_of_frame <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ hw/rtl/lgs_checker.sv @@
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks for the life generation stencil, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lgs_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  lgs_pkg::t_lgs_out              o_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready
);

    // stalled result keeps its payload
    `LGS_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data),
        "result changed while stalled")

    // empty output register never blocks the input side
    `LGS_NEVER(a_ready_when_empty, i_clk, i_rst_n,
        !o_out_valid && !o_in_ready,
        "input stalled with empty output")

    // a new result always follows an input transfer
    `LGS_ASSERT(a_out_from_input, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready),
        "result without input transfer")

    // register writes land only while nothing is in flight
    `LGS_NEVER(a_cfg_when_idle, i_clk, i_rst_n,
        i_cfg_valid && o_cfg_ready && (i_in_valid || o_out_valid),
        "register write with transfers pending")

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (.*);
